// ----- hw/rtl/acqr_pkg.sv -----
`timescale 1ns / 1ps

package acqr_pkg;

  localparam int NUM_SLAVES      = 2;
  localparam int SLAVE_W         = $clog2(NUM_SLAVES);
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_PAYLOAD_MAX = 13;

  localparam int OP_W       = 2;
  localparam int ADDR_W     = 7;
  localparam int SEQ_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int TIMER_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [TIMER_W-1:0] RETX_RESET = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE0_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE1_ADDR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETX_INTERVAL = 2'd2;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_STATUS = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NOSEND,
    ST_SEQ,
    ST_BYTE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic load_empty;
    logic load_seq;
    logic load_byte;
  } dp_cmd_t;

  typedef struct packed {
    logic send;
    logic plen_zero;
    logic byte_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/acqr_ctrl.sv -----
`timescale 1ns / 1ps

module acqr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  acqr_pkg::dp_stat_t stat,
  output acqr_pkg::dp_cmd_t  cmd
);
  import acqr_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.send ? ST_SEQ : ST_NOSEND;
        end
      end
      ST_NOSEND: begin
        if (stat.out_free) begin
          cmd.load_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_SEQ: begin
        if (stat.out_free) begin
          cmd.load_seq = 1'b1;
          state_nxt    = stat.plen_zero ? ST_IDLE : ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (stat.out_free) begin
          cmd.load_byte = 1'b1;
          if (stat.byte_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/acqr_dp.sv -----
`timescale 1ns / 1ps

module acqr_dp #(
  parameter int QUEUE_DEPTH = acqr_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_MAX = acqr_pkg::DEF_PAYLOAD_MAX
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [acqr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [acqr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [acqr_pkg::OP_W-1:0]           in_operation,
  input  logic [acqr_pkg::SLAVE_W-1:0]        in_slave,
  input  logic [acqr_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                                in_last_byte,
  input  logic [acqr_pkg::SEQ_W-1:0]          in_status_seq,
  input  logic                                in_status_crc_ok,
  input  logic                                in_init,
  input  acqr_pkg::dp_cmd_t                   cmd,
  output acqr_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_frame_valid,
  output logic [acqr_pkg::ADDR_W-1:0]         out_dest_address,
  output logic [acqr_pkg::BYTE_W-1:0]         out_frame_byte,
  output logic                                out_last,
  output logic                                out_synced,
  output logic                                out_acked,
  output logic                                out_overflow,
  output logic                                out_status_rejected
);
  import acqr_pkg::*;

  localparam int HW        = $clog2(QUEUE_DEPTH);
  localparam int CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int PW        = $clog2(PAYLOAD_MAX + 1);
  localparam int MEM_DEPTH = QUEUE_DEPTH << PW;

  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [HW:0]   DEPTH_S   = (HW + 1)'(QUEUE_DEPTH);
  localparam logic [HW-1:0] LAST_HEAD = HW'(QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] PMAX_C    = PW'(PAYLOAD_MAX);

  // configuration
  logic [ADDR_W-1:0]  slave0_addr_r;
  logic [ADDR_W-1:0]  slave1_addr_r;
  logic [TIMER_W-1:0] retx_interval_r;

  // queue control
  logic [HW-1:0]      head_r, head_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [PW-1:0]      fill_r, fill_nxt;
  logic [TIMER_W-1:0] countdown_r, countdown_nxt;
  logic [SEQ_W-1:0]   slave_seq_r [NUM_SLAVES];
  logic [PW-1:0]      idx_r, idx_nxt;

  // per-entry stores
  logic [SLAVE_W-1:0] entry_slave_r [QUEUE_DEPTH];
  logic [SEQ_W-1:0]   entry_seq_r   [QUEUE_DEPTH];
  logic [PW-1:0]      entry_plen_r  [QUEUE_DEPTH];
  logic [BYTE_W-1:0]  payload_mem   [MEM_DEPTH];
  logic [BYTE_W-1:0]  mem_q_r;

  // result flags of the current item
  logic acked_r, ovf_r, rej_r;

  // output register
  logic               out_valid_r;
  logic               out_frame_valid_r;
  logic [ADDR_W-1:0]  out_dest_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic               out_last_r;
  logic               out_synced_r;
  logic               out_acked_r;
  logic               out_ovf_r;
  logic               out_rej_r;

  logic [HW:0]        tail_sum;
  logic [HW-1:0]      tail;
  logic               full;
  logic               fill_room;
  logic [PW-1:0]      fill_inc;
  logic               push_ok;
  logic               commit;
  logic               status_ok;
  logic               hit;
  logic               tick_fire;
  logic [SEQ_W-1:0]   seq_new;
  logic               seq_we;
  logic [SEQ_W-1:0]   seq_wdata;
  logic [PW-1:0]      head_plen;
  logic [ADDR_W-1:0]  head_dest;
  logic               out_load;

  always_comb begin
    full      = (count_r == DEPTH_C);
    tail_sum  = {1'b0, head_r} + (HW + 1)'(count_r);
    tail      = (tail_sum >= DEPTH_S) ? HW'(tail_sum - DEPTH_S) : tail_sum[HW-1:0];
    fill_room = (fill_r < PMAX_C);
    fill_inc  = fill_room ? fill_r + PW'(1) : fill_r;
    push_ok   = (in_operation == OP_PUSH) && !full;
    commit    = push_ok && in_last_byte;
    status_ok = (in_operation == OP_STATUS) && in_status_crc_ok;
    hit       = status_ok && (count_r != '0) && (entry_slave_r[head_r] == in_slave) &&
                (entry_seq_r[head_r] == in_status_seq);
    tick_fire = (in_operation == OP_TICK) && (countdown_r == '0) && (count_r != '0);
    seq_new   = slave_seq_r[in_slave] + SEQ_W'(1);
    head_plen = entry_plen_r[head_r];
    head_dest = (entry_slave_r[head_r] == SLAVE_W'(1)) ? slave1_addr_r : slave0_addr_r;
    out_load  = cmd.load_empty || cmd.load_seq || cmd.load_byte;

    stat.send      = (commit && (count_r == '0)) || tick_fire;
    stat.plen_zero = (head_plen == '0);
    stat.byte_last = ((idx_r + PW'(1)) == head_plen);
    stat.out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    fill_nxt      = fill_r;
    countdown_nxt = countdown_r;
    seq_we        = 1'b0;
    seq_wdata     = seq_new;
    if (cmd.accept) begin
      case (in_operation)
        OP_PUSH: begin
          if (full) begin
            fill_nxt = '0;
          end else if (in_last_byte) begin
            seq_we    = 1'b1;
            fill_nxt  = '0;
            count_nxt = count_r + CW'(1);
            if (count_r == '0) begin
              countdown_nxt = retx_interval_r;
            end
          end else begin
            fill_nxt = fill_inc;
          end
        end
        OP_STATUS: begin
          if (status_ok && in_init) begin
            seq_we    = 1'b1;
            seq_wdata = in_status_seq;
          end
          if (hit) begin
            count_nxt     = count_r - CW'(1);
            head_nxt      = (head_r == LAST_HEAD) ? '0 : head_r + HW'(1);
            countdown_nxt = '0;
          end
        end
        OP_TICK: begin
          if (countdown_r != '0) begin
            countdown_nxt = countdown_r - TIMER_W'(1);
          end else if (count_r != '0) begin
            countdown_nxt = retx_interval_r;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.load_seq) begin
      idx_nxt = '0;
    end else if (cmd.load_byte) begin
      idx_nxt = idx_r + PW'(1);
    end else begin
      idx_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave0_addr_r   <= '0;
      slave1_addr_r   <= '0;
      retx_interval_r <= RETX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE0_ADDR:   slave0_addr_r   <= cfg_data[ADDR_W-1:0];
        CFG_SLAVE1_ADDR:   slave1_addr_r   <= cfg_data[ADDR_W-1:0];
        CFG_RETX_INTERVAL: retx_interval_r <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      fill_r      <= '0;
      countdown_r <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SLAVES; i++) begin
        slave_seq_r[i] <= '0;
      end
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      countdown_r <= countdown_nxt;
      idx_r       <= idx_nxt;
      if (seq_we) begin
        slave_seq_r[in_slave] <= seq_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && commit) begin
      entry_slave_r[tail] <= in_slave;
      entry_seq_r[tail]   <= seq_new;
      entry_plen_r[tail]  <= fill_inc;
    end
    if (cmd.accept) begin
      acked_r <= hit;
      ovf_r   <= (in_operation == OP_PUSH) && full;
      rej_r   <= (in_operation == OP_STATUS) && !in_status_crc_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && push_ok && fill_room) begin
      payload_mem[{tail, fill_r}] <= in_data_byte;
    end
    mem_q_r <= payload_mem[{head_r, idx_nxt}];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_synced_r <= (count_r == '0);
      out_acked_r  <= acked_r;
      out_ovf_r    <= ovf_r;
      out_rej_r    <= rej_r;
      if (cmd.load_empty) begin
        out_frame_valid_r <= 1'b0;
        out_dest_r        <= '0;
        out_byte_r        <= '0;
        out_last_r        <= 1'b1;
      end else if (cmd.load_seq) begin
        out_frame_valid_r <= 1'b1;
        out_dest_r        <= head_dest;
        out_byte_r        <= entry_seq_r[head_r];
        out_last_r        <= stat.plen_zero;
      end else begin
        out_frame_valid_r <= 1'b1;
        out_dest_r        <= head_dest;
        out_byte_r        <= mem_q_r;
        out_last_r        <= stat.byte_last;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_valid     = out_frame_valid_r;
  assign out_dest_address    = out_dest_r;
  assign out_frame_byte      = out_byte_r;
  assign out_last            = out_last_r;
  assign out_synced          = out_synced_r;
  assign out_acked           = out_acked_r;
  assign out_overflow        = out_ovf_r;
  assign out_status_rejected = out_rej_r;

endmodule

// ----- hw/rtl/acked_command_queue_retransmit_top.sv -----
// Channel  Direction  Beat contents
// cfg      in         cfg_we, cfg_index, cfg_data (write only)
// in       in         operation, slave, data_byte, last_byte, status_seq, status_crc_ok, init
// out      out        frame_valid, dest_address, frame_byte, last, synced, acked,
//                     overflow, status_rejected
//
// An input beat is accepted and is followed by its result beats: one beat for a
// command that sends nothing, 1 + payload length beats for a send, one per cycle while
// out_stall is low. A send walks the head command through the single read port of the
// payload memory; its payload length is at most PAYLOAD_MAX.
// Reset is synchronous; the payload memory and entry stores need no clearing.
// out_stall holds the result register and the sequencer; in_stall is high until the
// last result beat of the current item has been loaded.
`timescale 1ns / 1ps

module acked_command_queue_retransmit_top #(
  parameter int QUEUE_DEPTH = acqr_pkg::DEF_QUEUE_DEPTH,
  parameter int PAYLOAD_MAX = acqr_pkg::DEF_PAYLOAD_MAX
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acqr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acqr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [acqr_pkg::OP_W-1:0]       in_operation,
  input  logic [acqr_pkg::SLAVE_W-1:0]    in_slave,
  input  logic [acqr_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            in_last_byte,
  input  logic [acqr_pkg::SEQ_W-1:0]      in_status_seq,
  input  logic                            in_status_crc_ok,
  input  logic                            in_init,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_frame_valid,
  output logic [acqr_pkg::ADDR_W-1:0]     out_dest_address,
  output logic [acqr_pkg::BYTE_W-1:0]     out_frame_byte,
  output logic                            out_last,
  output logic                            out_synced,
  output logic                            out_acked,
  output logic                            out_overflow,
  output logic                            out_status_rejected
);
  import acqr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  acqr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  acqr_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_operation        (in_operation),
    .in_slave            (in_slave),
    .in_data_byte        (in_data_byte),
    .in_last_byte        (in_last_byte),
    .in_status_seq       (in_status_seq),
    .in_status_crc_ok    (in_status_crc_ok),
    .in_init             (in_init),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_valid     (out_frame_valid),
    .out_dest_address    (out_dest_address),
    .out_frame_byte      (out_frame_byte),
    .out_last            (out_last),
    .out_synced          (out_synced),
    .out_acked           (out_acked),
    .out_overflow        (out_overflow),
    .out_status_rejected (out_status_rejected)
  );

`ifndef SYNTH
  a_ovf_not_synced : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> !out_synced)
    else $error("overflow reported with empty queue");

  a_empty_is_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_valid) |-> out_last)
    else $error("non-frame result beat not marked last");

  a_flags_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_acked && out_status_rejected))
    else $error("status both acknowledged and rejected");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before results were produced");
`endif

endmodule
